/* src/programmable_mealy_moore_fsm_assert.svh */
// assertion macros for the table-driven state machine
// used by the top level; needs nothing else
`ifndef PROGRAMMABLE_MEALY_MOORE_FSM_ASSERT_SVH
`define PROGRAMMABLE_MEALY_MOORE_FSM_ASSERT_SVH

// same-cycle implication under synchronous reset
`define PMFSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define PMFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pmfsm_pkg.sv */
// shared types, widths and codes of the table-driven state machine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pmfsm_pkg;

    // default sizes of the tables
    localparam int DEF_MAX_STATES   = 64;
    localparam int DEF_MAX_SYMBOLS  = 16;
    localparam int DEF_OUTPUT_WIDTH = 16;

    // field widths
    localparam int OP_W      = 2;
    localparam int SYM_W     = 4;
    localparam int ROW_W     = 6;
    localparam int NXT_W     = 7;
    localparam int VAL_W     = 16;
    localparam int CODE_W    = 16;
    localparam int STATE_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam int SCNT_W    = 7;
    localparam int ICNT_W    = 5;

    // operations
    localparam logic [OP_W-1:0] OP_STEP     = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_TRANS = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_OUT   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART  = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDEF    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd3;

    // machine kinds
    localparam logic KIND_MEALY = 1'b0;
    localparam logic KIND_MOORE = 1'b1;

    // one access to both tables
    typedef struct packed {
        logic               rd_en;
        logic               wr_trans;
        logic               wr_out;
        logic [ROW_W-1:0]   row;
        logic [SYM_W-1:0]   tr_col;
        logic [SYM_W-1:0]   out_col;
        logic [NXT_W-1:0]   tr_data;
        logic [VAL_W-1:0]   out_data;
    } t_store_req;

endpackage

`default_nettype wire

/* src/programmable_mealy_moore_fsm.sv */
// top level of the programmable table-driven mealy/moore state machine
// depends on pmfsm_pkg, pmfsm_store, pmfsm_ram and the assertion macro header
//
//   channel   direction  handshake                  payload
//   in        to block   i_in_valid / o_in_ready    i_operation i_symbol i_row_state
//                                                   i_next_state i_output_value
//   out       from block o_out_valid / i_out_ready  o_output_code o_present_state o_status
//   cfg       to block   i_cfg_we (no wait)         i_cfg_index i_cfg_data
//
// every transaction has an accept phase and an exec phase: the accept cycle issues the
// table reads at the current state, then the exec phase evaluates and writes a table or
// updates the state. registered ram read data and a next step needing that state set this.
// one item is in flight at a time, so a table write never meets a read of the same entry.
// a result waiting in the output register stalls evaluation; reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
`include "programmable_mealy_moore_fsm_assert.svh"

module programmable_mealy_moore_fsm #(
    parameter int MAX_STATES   = pmfsm_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS  = pmfsm_pkg::DEF_MAX_SYMBOLS,
    parameter int OUTPUT_WIDTH = pmfsm_pkg::DEF_OUTPUT_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [pmfsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pmfsm_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [pmfsm_pkg::OP_W-1:0]        i_operation,
    input  wire logic [pmfsm_pkg::SYM_W-1:0]       i_symbol,
    input  wire logic [pmfsm_pkg::ROW_W-1:0]       i_row_state,
    input  wire logic [pmfsm_pkg::NXT_W-1:0]       i_next_state,
    input  wire logic [pmfsm_pkg::VAL_W-1:0]       i_output_value,
    // results
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [pmfsm_pkg::CODE_W-1:0]           o_output_code,
    output logic [pmfsm_pkg::STATE_W-1:0]          o_present_state,
    output logic [pmfsm_pkg::STATUS_W-1:0]         o_status
);
    import pmfsm_pkg::*;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_EXEC = 1'b1;

    // configuration registers
    logic                r_machine_kind;
    logic [SCNT_W-1:0]   r_state_count;
    logic [ICNT_W-1:0]   r_input_count;
    logic [STATE_W-1:0]  r_start_state;

    // control and current state
    logic                r_phase;
    logic                n_phase;
    logic [STATE_W-1:0]  r_state;
    logic [STATE_W-1:0]  n_state;

    // captured transaction
    logic [OP_W-1:0]     r_op;
    logic [SYM_W-1:0]    r_sym;
    logic [ROW_W-1:0]    r_row;
    logic [NXT_W-1:0]    r_next;
    logic [VAL_W-1:0]    r_value;

    // output register
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_out_code;
    logic [STATE_W-1:0]  r_out_state;
    logic [STATUS_W-1:0] r_out_status;

    // evaluation
    logic                in_accept;
    logic                finish;
    logic                sym_ok;
    logic                row_ok;
    logic                cur_ok;
    logic                tgt_ok;
    logic                wr_trans;
    logic                wr_out;
    logic [CODE_W-1:0]   n_code;
    logic [STATUS_W-1:0] n_status;
    logic [NXT_W-1:0]    tr_rdata;
    logic [OUTPUT_WIDTH-1:0] out_rdata;
    logic [63:0]         out_rd_wide;
    t_store_req          store_req;

    // handshakes
    assign o_in_ready = (r_phase == PH_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign finish     = (r_phase == PH_EXEC) && (!r_out_valid || i_out_ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_kind <= KIND_MEALY;
            r_state_count  <= SCNT_W'(1);
            r_input_count  <= ICNT_W'(1);
            r_start_state  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KIND:        r_machine_kind <= i_cfg_data[0];
                REG_STATE_COUNT: r_state_count  <= i_cfg_data[SCNT_W-1:0];
                REG_INPUT_COUNT: r_input_count  <= i_cfg_data[ICNT_W-1:0];
                REG_START_STATE: r_start_state  <= i_cfg_data[STATE_W-1:0];
                default:         r_start_state  <= r_start_state;
            endcase
        end
    end

    // table access: reads at accept, writes when the item finishes
    always_comb begin
        store_req          = '0;
        store_req.rd_en    = in_accept;
        store_req.wr_trans = finish && wr_trans;
        store_req.wr_out   = finish && wr_out;
        store_req.tr_data  = r_next;
        store_req.out_data = r_value;
        if (r_phase == PH_EXEC) begin
            store_req.row     = r_row;
            store_req.tr_col  = r_sym;
            store_req.out_col = r_sym;
        end else begin
            store_req.row     = r_state;
            store_req.tr_col  = i_symbol;
            store_req.out_col = (r_machine_kind == KIND_MOORE) ? '0 : i_symbol;
        end
    end

    pmfsm_store #(
        .MAX_STATES   (MAX_STATES),
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .OUTPUT_WIDTH (OUTPUT_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_req       (store_req),
        .o_tr_rdata  (tr_rdata),
        .o_out_rdata (out_rdata)
    );

    // range checks against the active limits
    assign sym_ok = ({1'b0, r_sym} < r_input_count) && (32'(r_sym) < MAX_SYMBOLS);
    assign row_ok = ({1'b0, r_row} < r_state_count) && (32'(r_row) < MAX_STATES);
    assign cur_ok = ({1'b0, r_state} < r_state_count) && (32'(r_state) < MAX_STATES);
    assign tgt_ok = (tr_rdata < r_state_count) && (32'(tr_rdata) < MAX_STATES);

    assign out_rd_wide = 64'(out_rdata);

    // evaluate the captured transaction
    always_comb begin
        n_status = ST_OK;
        n_code   = '0;
        n_state  = r_state;
        wr_trans = 1'b0;
        wr_out   = 1'b0;
        unique case (r_op) inside
            OP_WR_TRANS, OP_WR_OUT: begin
                if (!row_ok || !sym_ok) begin
                    n_status = ST_BAD_ADDR;
                end else begin
                    wr_trans = (r_op == OP_WR_TRANS);
                    wr_out   = (r_op == OP_WR_OUT);
                end
            end
            OP_RESTART: begin
                n_state = r_start_state;
            end
            default: begin
                if (!sym_ok) begin
                    n_status = ST_UNKNOWN;
                end else if (!cur_ok || !tgt_ok) begin
                    n_status = ST_UNDEF;
                end else begin
                    n_code  = out_rd_wide[CODE_W-1:0];
                    n_state = tr_rdata[STATE_W-1:0];
                end
            end
        endcase
    end

    // phase sequencer
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (in_accept) n_phase = PH_EXEC;
            PH_EXEC: if (finish)    n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (finish) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload capture and result data
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_sym   <= i_symbol;
            r_row   <= i_row_state;
            r_next  <= i_next_state;
            r_value <= i_output_value;
        end
        if (finish) begin
            r_out_code   <= n_code;
            r_out_state  <= n_state;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_output_code   = r_out_code;
    assign o_present_state = r_out_state;
    assign o_status        = r_out_status;

    // checks
    `PMFSM_ASSERT_NOW(a_no_rd_wr_overlap, i_clk, i_rst_n, store_req.rd_en, !store_req.wr_trans && !store_req.wr_out, "table read and write in the same cycle")
    `PMFSM_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, in_accept, r_phase == PH_EXEC, "accepted transaction did not reach evaluation")
    `PMFSM_ASSERT_NEXT(a_state_only_on_finish, i_clk, i_rst_n, !finish, $stable(r_state), "state changed outside a finishing transaction")
    `PMFSM_ASSERT_NOW(a_step_ok_in_range, i_clk, i_rst_n, finish && (r_op == OP_STEP) && (n_status == ST_OK), SCNT_W'(n_state) < r_state_count, "successful step moved to an unused state")

endmodule

`default_nettype wire

/* src/pmfsm_ram.sv */
// generic single-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pmfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, data held while no read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/pmfsm_store.sv */
// transition and output tables, each in its own ram, with row/column addressing
// depends on pmfsm_pkg and pmfsm_ram
`timescale 1ns / 1ps
`default_nettype none

module pmfsm_store #(
    parameter int MAX_STATES   = pmfsm_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS  = pmfsm_pkg::DEF_MAX_SYMBOLS,
    parameter int OUTPUT_WIDTH = pmfsm_pkg::DEF_OUTPUT_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire pmfsm_pkg::t_store_req         i_req,
    output logic [pmfsm_pkg::NXT_W-1:0]        o_tr_rdata,
    output logic [OUTPUT_WIDTH-1:0]            o_out_rdata
);
    import pmfsm_pkg::*;

    localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0]           tr_addr;
    logic [AW-1:0]           out_addr;
    logic [63:0]             out_wide;
    logic [OUTPUT_WIDTH-1:0] out_wdata;

    // row-major address: row * MAX_SYMBOLS + column
    assign tr_addr  = AW'(32'(i_req.row) * 32'(MAX_SYMBOLS) + 32'(i_req.tr_col));
    assign out_addr = AW'(32'(i_req.row) * 32'(MAX_SYMBOLS) + 32'(i_req.out_col));

    // output entries keep OUTPUT_WIDTH bits of the written value
    assign out_wide  = 64'(i_req.out_data);
    assign out_wdata = out_wide[OUTPUT_WIDTH-1:0];

    pmfsm_ram #(
        .WIDTH (NXT_W),
        .DEPTH (DEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_trans),
        .i_re    (i_req.rd_en),
        .i_addr  (tr_addr),
        .i_wdata (i_req.tr_data),
        .o_rdata (o_tr_rdata)
    );

    pmfsm_ram #(
        .WIDTH (OUTPUT_WIDTH),
        .DEPTH (DEPTH)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_out),
        .i_re    (i_req.rd_en),
        .i_addr  (out_addr),
        .i_wdata (out_wdata),
        .o_rdata (o_out_rdata)
    );

endmodule

`default_nettype wire
